### src/dtc_pkg.sv
// shared types, constants and the arctangent table for the tilt combiner
// used by every module of the block; no dependencies
package dtc_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int ROOT_STEPS        = 32;

  // register indexes
  localparam logic [2:0] REG_X_SYS  = 3'd0;
  localparam logic [2:0] REG_Y_SYS  = 3'd1;
  localparam logic [2:0] REG_X_USR  = 3'd2;
  localparam logic [2:0] REG_Y_USR  = 3'd3;
  localparam logic [2:0] REG_X_INST = 3'd4;
  localparam logic [2:0] REG_Y_INST = 3'd5;

  localparam logic [24:0] HALF_TURN    = 25'd1800000;
  localparam logic [24:0] QUARTER_TURN = 25'd900000;
  localparam logic [24:0] MOD_BIAS     = 25'd9000000;
  localparam logic [18:0] TILT_LIMIT   = 19'd300000;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [63:0] ONE_Q60     = 64'd1 << 60;
  localparam logic [63:0] QUARTER_Q60 = 64'd1 << 58;

  typedef logic signed [33:0] cval_t;
  typedef logic signed [31:0] aval_t;

  typedef struct packed {
    cval_t x;
    cval_t y;
    aval_t z;
  } cordic_t;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] res;
  } root_t;

  typedef struct packed {
    logic signed [22:0] sys_x;
    logic signed [22:0] sys_y;
    logic signed [23:0] usr_x;
    logic signed [23:0] usr_y;
    logic signed [23:0] cor_x;
    logic signed [23:0] cor_y;
    logic               sat;
  } side_t;

  // atan(2^-i) in 0.0001/256 degree
  function automatic aval_t atan_lut(input int i);
    aval_t r;
    case (i)
      0: r = 32'sd115200000;
      1: r = 32'sd68006531;
      2: r = 32'sd35932783;
      3: r = 32'sd18240042;
      4: r = 32'sd9155416;
      5: r = 32'sd4582171;
      6: r = 32'sd2291645;
      7: r = 32'sd1145892;
      8: r = 32'sd572955;
      9: r = 32'sd286479;
      10: r = 32'sd143239;
      11: r = 32'sd71620;
      12: r = 32'sd35810;
      13: r = 32'sd17905;
      14: r = 32'sd8952;
      15: r = 32'sd4476;
      16: r = 32'sd2238;
      17: r = 32'sd1119;
      18: r = 32'sd560;
      19: r = 32'sd280;
      20: r = 32'sd140;
      21: r = 32'sd70;
      22: r = 32'sd35;
      23: r = 32'sd17;
      24: r = 32'sd9;
      25: r = 32'sd4;
      26: r = 32'sd2;
      27: r = 32'sd1;
      28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

### src/dual_axis_tilt_combiner_unit.sv
// top level of the dual-axis tilt combiner: config registers, cell rows, output skid
// depends on dtc_pkg, dtc_front, dtc_cordic_cell, dtc_root_cell
//
//  channel | direction | payload
//  in_     | slave     | raw x/y angle pair
//  out_    | master    | relative, corrected angles, plane tilt, saturation flag
//  cfg_    | write     | six offset registers
//
// one transaction per cycle while the skid register is empty; results pass through
// the sine cell row, the 32-cell root rows and the vectoring cell row.
// rst_n clears valid bits and offset registers synchronously.
// a stalled result parks in a skid register; the cell rows freeze while it is full.
module dual_axis_tilt_combiner_unit #(
  parameter int CORDIC_STAGES = dtc_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // raw_x_angle, raw_y_angle
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [167:0]  out_tdata,  // x/y_system_relative, x/y_user_relative,
                                    // x/y_corrected, plane_tilt
  output logic          out_tuser,  // tilt_saturated
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [21:0]   cfg_wdata
);

  localparam int N     = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int RS    = dtc_pkg::ROOT_STEPS;
  localparam int DEPTH = 2 * N + RS + 3;

  logic signed [21:0] reg_r [6];
  logic               en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) reg_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dtc_pkg::REG_X_SYS:  reg_r[0] <= cfg_wdata;
        dtc_pkg::REG_Y_SYS:  reg_r[1] <= cfg_wdata;
        dtc_pkg::REG_X_USR:  reg_r[2] <= cfg_wdata;
        dtc_pkg::REG_Y_USR:  reg_r[3] <= cfg_wdata;
        dtc_pkg::REG_X_INST: reg_r[4] <= cfg_wdata;
        dtc_pkg::REG_Y_INST: reg_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic            f_vld;
  dtc_pkg::side_t  f_side;
  dtc_pkg::aval_t  f_zx, f_zy;

  dtc_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_vld(in_tvalid),
    .raw_x(in_tdata[21:0]), .raw_y(in_tdata[43:22]),
    .sys_zero_x(reg_r[0]), .sys_zero_y(reg_r[1]),
    .usr_zero_x(reg_r[2]), .usr_zero_y(reg_r[3]),
    .inst_x(reg_r[4]), .inst_y(reg_r[5]),
    .out_vld(f_vld), .out_side(f_side), .out_zx(f_zx), .out_zy(f_zy)
  );

  // sine rows
  dtc_pkg::cordic_t sx [N+1];
  dtc_pkg::cordic_t sy [N+1];
  assign sx[0] = '{x: dtc_pkg::CORDIC_GAIN_Q30, y: '0, z: f_zx};
  assign sy[0] = '{x: dtc_pkg::CORDIC_GAIN_Q30, y: '0, z: f_zy};

  for (genvar g = 0; g < N; g++) begin : g_sine
    dtc_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_cx (
      .clk(clk), .en(en), .d(sx[g]), .q(sx[g+1]));
    dtc_cordic_cell #(.STAGE(g), .VECTOR(1'b0)) u_cy (
      .clk(clk), .en(en), .d(sy[g]), .q(sy[g+1]));
  end

  // squares and sum
  logic [30:0] mag_x, mag_y;
  logic [61:0] px_r, py_r;
  logic [63:0] q_r, qc_r, q_sum;
  logic        sat;

  always_comb begin
    mag_x = sx[N].y[33] ? 31'(-sx[N].y) : sx[N].y[30:0];
    mag_y = sy[N].y[33] ? 31'(-sy[N].y) : sy[N].y[30:0];
    q_sum = 64'(px_r) + 64'(py_r);
    sat   = q_sum >= dtc_pkg::QUARTER_Q60;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= 62'(mag_x) * 62'(mag_x);
      py_r <= 62'(mag_y) * 62'(mag_y);
      q_r  <= q_sum;
      qc_r <= dtc_pkg::ONE_Q60 - 64'(px_r) - 64'(py_r);
    end
  end

  // root rows
  dtc_pkg::root_t rs [RS+1];
  dtc_pkg::root_t rc [RS+1];
  assign rs[0] = '{v: q_r, res: '0};
  assign rc[0] = '{v: qc_r, res: '0};

  for (genvar g = 0; g < RS; g++) begin : g_root
    dtc_root_cell #(.STEP(g)) u_rs (.clk(clk), .en(en), .d(rs[g]), .q(rs[g+1]));
    dtc_root_cell #(.STEP(g)) u_rc (.clk(clk), .en(en), .d(rc[g]), .q(rc[g+1]));
  end

  // vectoring row
  dtc_pkg::cordic_t vc [N+1];
  assign vc[0] = '{x: rc[RS].res[33:0], y: rs[RS].res[33:0], z: '0};

  for (genvar g = 0; g < N; g++) begin : g_vec
    dtc_cordic_cell #(.STAGE(g), .VECTOR(1'b1)) u_cv (
      .clk(clk), .en(en), .d(vc[g]), .q(vc[g+1]));
  end

  logic [18:0] tilt_r;
  logic [23:0] zsh;

  always_comb begin
    zsh = vc[N].z[31] ? 24'd0 : vc[N].z[31:8];
  end

  always_ff @(posedge clk) begin
    if (en) tilt_r <= (zsh > 24'(dtc_pkg::TILT_LIMIT)) ? dtc_pkg::TILT_LIMIT : zsh[18:0];
  end

  // sideband and valid line alongside the cells
  dtc_pkg::side_t side_r [DEPTH];
  dtc_pkg::side_t side_tap;
  logic [DEPTH-1:0] vld_r;

  // saturation flag joins the sideband once the squares are summed
  always_comb begin
    side_tap     = side_r[N];
    side_tap.sat = sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], f_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= f_side;
      for (int k = 1; k < DEPTH; k++) begin
        side_r[k] <= (k == N + 1) ? side_tap : side_r[k-1];
      end
    end
  end

  // output register and skid
  logic [167:0] tail_data, out_data_r, skid_data_r;
  logic         tail_sat, out_sat_r, skid_sat_r;
  logic         out_vld_r, skid_vld_r;
  logic         tail_vld;

  assign en       = !skid_vld_r;
  assign tail_vld = vld_r[DEPTH-1];
  assign tail_sat = side_r[DEPTH-1].sat;
  assign tail_data = {7'd0,
                      side_r[DEPTH-1].sat ? dtc_pkg::TILT_LIMIT : tilt_r,
                      side_r[DEPTH-1].cor_y, side_r[DEPTH-1].cor_x,
                      side_r[DEPTH-1].usr_y, side_r[DEPTH-1].usr_x,
                      side_r[DEPTH-1].sys_y, side_r[DEPTH-1].sys_x};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (skid_vld_r) begin
        if (out_tready) begin
          out_data_r <= skid_data_r;
          out_sat_r  <= skid_sat_r;
          skid_vld_r <= 1'b0;
        end
      end else if (tail_vld) begin
        if (!out_vld_r || out_tready) begin
          out_data_r <= tail_data;
          out_sat_r  <= tail_sat;
          out_vld_r  <= 1'b1;
        end else begin
          skid_data_r <= tail_data;
          skid_sat_r  <= tail_sat;
          skid_vld_r  <= 1'b1;
        end
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a transaction while output is empty");
  a_sat_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[160:142] == dtc_pkg::TILT_LIMIT))
    else $error("saturated tilt not clamped");
  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[160:142] <= dtc_pkg::TILT_LIMIT))
    else $error("plane tilt above limit");
`endif

endmodule

### src/dtc_front.sv
// offset correction and angle reduction ahead of the sine cells
// depends on dtc_pkg
module dtc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [21:0]       raw_x,
  input  logic signed [21:0]       raw_y,
  input  logic signed [21:0]       sys_zero_x,
  input  logic signed [21:0]       sys_zero_y,
  input  logic signed [21:0]       usr_zero_x,
  input  logic signed [21:0]       usr_zero_y,
  input  logic signed [21:0]       inst_x,
  input  logic signed [21:0]       inst_y,
  output logic                     out_vld,
  output dtc_pkg::side_t           out_side,
  output dtc_pkg::aval_t           out_zx,
  output dtc_pkg::aval_t           out_zy
);

  logic [2:0]          vld_r;
  dtc_pkg::side_t      s1_r, s2_r, s3_r;
  logic [24:0]         mx_r, my_r;
  dtc_pkg::aval_t      zx_r, zy_r;

  logic signed [22:0]  sysx, sysy;
  logic signed [23:0]  usrx, usry, corx, cory;
  logic [24:0]         mx_nxt, my_nxt;

  function automatic logic [24:0] reduce_hi(input logic signed [23:0] a);
    logic [24:0] v;
    v = 25'(signed'({a[23], a})) + dtc_pkg::MOD_BIAS;
    if (v >= 25'(8 * 1800000)) v = v - 25'(8 * 1800000);
    if (v >= 25'(4 * 1800000)) v = v - 25'(4 * 1800000);
    return v;
  endfunction

  function automatic dtc_pkg::aval_t reduce_lo(input logic [24:0] a);
    logic [24:0] v;
    v = a;
    if (v >= 25'(2 * 1800000)) v = v - 25'(2 * 1800000);
    if (v >= dtc_pkg::HALF_TURN) v = v - dtc_pkg::HALF_TURN;
    if (v > dtc_pkg::QUARTER_TURN) v = dtc_pkg::HALF_TURN - v;
    return dtc_pkg::aval_t'({7'd0, v} << 8);
  endfunction

  always_comb begin
    sysx = 23'(raw_x) - 23'(sys_zero_x);
    sysy = 23'(raw_y) - 23'(sys_zero_y);
    usrx = 24'(sysx) - 24'(usr_zero_x);
    usry = 24'(sysy) - 24'(usr_zero_y);
    corx = usrx + 24'(inst_x);
    cory = usry + 24'(inst_y);
    mx_nxt = reduce_hi(s1_r.cor_x);
    my_nxt = reduce_hi(s1_r.cor_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= '{sys_x: sysx, sys_y: sysy, usr_x: usrx, usr_y: usry,
                cor_x: corx, cor_y: cory, sat: 1'b0};
      s2_r <= s1_r;
      mx_r <= mx_nxt;
      my_r <= my_nxt;
      s3_r <= s2_r;
      zx_r <= reduce_lo(mx_r);
      zy_r <= reduce_lo(my_r);
    end
  end

  assign out_vld  = vld_r[2];
  assign out_side = s3_r;
  assign out_zx   = zx_r;
  assign out_zy   = zy_r;

endmodule

### src/dtc_cordic_cell.sv
// one cordic micro-rotation, rotation or vectoring mode
// depends on dtc_pkg
module dtc_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  logic              clk,
  input  logic              en,
  input  dtc_pkg::cordic_t  d,
  output dtc_pkg::cordic_t  q
);

  localparam dtc_pkg::aval_t ATAN = dtc_pkg::atan_lut(STAGE);

  dtc_pkg::cordic_t q_r, q_nxt;
  dtc_pkg::cval_t   dx, dy;
  logic             pos;

  always_comb begin
    dx  = d.y >>> STAGE;
    dy  = d.x >>> STAGE;
    // vectoring drives y to zero, rotation drives z to zero
    pos = VECTOR ? !d.y[33] : !d.z[31];
    if (!VECTOR && pos) begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - ATAN;
    end else if (!VECTOR) begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + ATAN;
    end else if (pos) begin
      q_nxt.x = d.x + dx;
      q_nxt.y = d.y - dy;
      q_nxt.z = d.z + ATAN;
    end else begin
      q_nxt.x = d.x - dx;
      q_nxt.y = d.y + dy;
      q_nxt.z = d.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

### src/dtc_root_cell.sv
// one digit step of the bitwise square root
// depends on dtc_pkg
module dtc_root_cell #(
  parameter int STEP = 0
) (
  input  logic            clk,
  input  logic            en,
  input  dtc_pkg::root_t  d,
  output dtc_pkg::root_t  q
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  dtc_pkg::root_t q_r, q_nxt;
  logic [63:0]    t;

  always_comb begin
    t = d.res + BIT;
    if (d.v >= t) begin
      q_nxt.v   = d.v - t;
      q_nxt.res = (d.res >> 1) + BIT;
    end else begin
      q_nxt.v   = d.v;
      q_nxt.res = d.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) q_r <= q_nxt;
  end

  assign q = q_r;

endmodule
